// ----- sv/piodh_pkg.sv -----
// Shared types and constants for the mode 0 parallel I/O block with disk handshake.
package piodh_pkg;

  typedef enum logic [1:0] {
    CMD_HOST_READ     = 2'd0,
    CMD_HOST_WRITE    = 2'd1,
    CMD_PARTNER_PUT   = 2'd2,
    CMD_PARTNER_FETCH = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    PORT_A    = 2'd0,
    PORT_B    = 2'd1,
    PORT_C    = 2'd2,
    PORT_CTRL = 2'd3
  } port_e;

  // Mode word bits: port C halves configured as input.
  localparam int unsigned MODE_C_LOW_IN  = 0;
  localparam int unsigned MODE_C_HIGH_IN = 3;

  // Port C low nibble handshake bits.
  localparam int unsigned PC_PRINTER = 0;  // high: port A writes go to printer
  localparam int unsigned PC_TAKE_B  = 1;  // low: partner byte into port B
  localparam int unsigned PC_GIVE_A  = 2;  // low: port A handed to partner

  typedef struct packed {
    command_e    command;
    port_e       port_select;
    logic [7:0]  host_byte;
    logic [7:0]  partner_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        printer_strobe;
    logic [7:0]  printer_byte;
    logic [7:0]  partner_read_byte;
    logic        partner_read_valid;
  } res_t;

endpackage

// ----- sv/piodh_core.sv -----
// Port latches, handshake flags and the per-transaction update logic.
module piodh_core import piodh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,   // apply req_i this cycle
  input  req_t req_i,
  output res_t res_o
);

  logic [7:0] port_a_q, port_a_d;
  logic [7:0] port_b_q, port_b_d;
  logic [3:0] pc_low_q, pc_low_d;
  logic [3:0] pc_high_q, pc_high_d;   // bits 7..4 of port C
  logic [7:0] mode_q, mode_d;
  logic [7:0] p_in_q, p_in_d;
  logic [7:0] p_out_q, p_out_d;
  logic       wr_rdy_q, wr_rdy_d;
  logic       rd_rdy_q, rd_rdy_d;

  always_comb begin
    logic [3:0] hi_rebuilt;
    logic [3:0] lo_new;
    hi_rebuilt = {1'b0, pc_high_q[2], rd_rdy_q, wr_rdy_q};
    lo_new     = req_i.host_byte[3:0];

    port_a_d  = port_a_q;
    port_b_d  = port_b_q;
    pc_low_d  = pc_low_q;
    pc_high_d = pc_high_q;
    mode_d    = mode_q;
    p_in_d    = p_in_q;
    p_out_d   = p_out_q;
    wr_rdy_d  = wr_rdy_q;
    rd_rdy_d  = rd_rdy_q;
    res_o     = '0;

    unique case (req_i.command)
      CMD_HOST_READ: begin
        unique case (req_i.port_select)
          PORT_A: res_o.read_byte = port_a_q;
          PORT_B: res_o.read_byte = port_b_q;
          PORT_C: begin
            if (mode_q[MODE_C_HIGH_IN]) begin
              // high half rebuilt from handshake flags, sticks in the latch
              pc_high_d       = hi_rebuilt;
              res_o.read_byte = {hi_rebuilt, pc_low_q};
            end else begin
              res_o.read_byte = {pc_high_q, pc_low_q};
            end
          end
          default: res_o.read_byte = '0;
        endcase
      end
      CMD_HOST_WRITE: begin
        unique case (req_i.port_select)
          PORT_A: begin
            port_a_d = req_i.host_byte;
            if (pc_low_q[PC_PRINTER]) begin
              res_o.printer_strobe = 1'b1;
              res_o.printer_byte   = req_i.host_byte;
            end
          end
          PORT_B: port_b_d = req_i.host_byte;
          PORT_C: begin
            if (!mode_q[MODE_C_LOW_IN]) begin
              pc_low_d = lo_new;
              if (!lo_new[PC_TAKE_B]) begin
                port_b_d = p_in_q;
                wr_rdy_d = 1'b0;
              end
              if (!lo_new[PC_GIVE_A]) begin
                p_out_d  = port_a_q;
                rd_rdy_d = 1'b1;
              end
            end
            if (!mode_q[MODE_C_HIGH_IN]) pc_high_d = req_i.host_byte[7:4];
          end
          default: mode_d = req_i.host_byte;
        endcase
      end
      CMD_PARTNER_PUT: begin
        p_in_d   = req_i.partner_byte;
        wr_rdy_d = 1'b1;
      end
      default: begin
        res_o.partner_read_byte  = p_out_q;
        res_o.partner_read_valid = rd_rdy_q;
        rd_rdy_d                 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q  <= '0;
      port_b_q  <= '0;
      pc_low_q  <= '0;
      pc_high_q <= '0;
      mode_q    <= '0;
      p_in_q    <= '0;
      p_out_q   <= '0;
      wr_rdy_q  <= 1'b0;
      rd_rdy_q  <= 1'b0;
    end else if (fire_i) begin
      port_a_q  <= port_a_d;
      port_b_q  <= port_b_d;
      pc_low_q  <= pc_low_d;
      pc_high_q <= pc_high_d;
      mode_q    <= mode_d;
      p_in_q    <= p_in_d;
      p_out_q   <= p_out_d;
      wr_rdy_q  <= wr_rdy_d;
      rd_rdy_q  <= rd_rdy_d;
    end
  end

endmodule

// ----- sv/pio_mode0_with_disk_handshake_top.sv -----
// Top level of the mode 0 parallel I/O block with disk handshake.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus transaction:
//   a host read or write of port A, B, C or the command port, or a disk
//   unit deposit or fetch. Output channel (out_valid_o / out_stall_i)
//   returns exactly one result transaction per input, in order.
// Path: an accepted transaction lands in the input register; its result
//   is then registered in the result register and shown from there on.
// Throughput: one transaction per clock while out_stall_i is low. The whole update of the port
//   latches and flags is a single mux level in front of the result
//   register, so back-to-back transactions see each other's effects.
// Stalls: while out_stall_i holds a pending result, the input register
//   keeps its transaction and in_stall_o rises only if it is occupied;
//   the input side thus keeps one transaction buffered behind the result.
// Reset: rst_ni (async, active low) clears all latches, the mode word,
//   the handshake flags and both valid bits.
module pio_mode0_with_disk_handshake_top import piodh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [1:0] port_select_i,
  input  logic [7:0] host_byte_i,
  input  logic [7:0] partner_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic       printer_strobe_o,
  output logic [7:0] printer_byte_o,
  output logic [7:0] partner_read_byte_o,
  output logic       partner_read_valid_o
);

  logic in_valid_q;
  req_t req_q;
  logic out_valid_q;
  res_t res_q;
  res_t res_d;
  logic advance;   // input register moves into the result register
  logic in_take;

  // Result register free, or being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  piodh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .res_o  (res_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.command      <= command_e'(command_i);
      req_q.port_select  <= port_e'(port_select_i);
      req_q.host_byte    <= host_byte_i;
      req_q.partner_byte <= partner_byte_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o          = out_valid_q;
  assign read_byte_o          = res_q.read_byte;
  assign printer_strobe_o     = res_q.printer_strobe;
  assign printer_byte_o       = res_q.printer_byte;
  assign partner_read_byte_o  = res_q.partner_read_byte;
  assign partner_read_valid_o = res_q.partner_read_valid;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the mode 0 parallel I/O block with disk handshake.
module tb_top;
  import piodh_pkg::*;

  localparam int unsigned RANDOM_ACCESSES = 900;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int unsigned DRAIN_CYCLES    = 8;

  typedef struct {
    command_e   cmd;
    port_e      port;
    logic [7:0] host_byte;
    logic [7:0] disk_byte;
    bit         typed;  // use the result written in the row, not the predictor
    res_t       want;
  } access_row_t;

  localparam res_t ALL_ZERO = '0;

  logic       clk_i                = 1'b0;
  logic       rst_ni               = 1'b0;
  logic       in_valid_i           = 1'b0;
  logic       in_stall_o;
  logic [1:0] command_i            = '0;
  logic [1:0] port_select_i        = '0;
  logic [7:0] host_byte_i          = '0;
  logic [7:0] partner_byte_i       = '0;
  logic       out_valid_o;
  logic       out_stall_i          = 1'b0;
  logic [7:0] read_byte_o;
  logic       printer_strobe_o;
  logic [7:0] printer_byte_o;
  logic [7:0] partner_read_byte_o;
  logic       partner_read_valid_o;

  pio_mode0_with_disk_handshake_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .command_i            (command_i),
    .port_select_i        (port_select_i),
    .host_byte_i          (host_byte_i),
    .partner_byte_i       (partner_byte_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .read_byte_o          (read_byte_o),
    .printer_strobe_o     (printer_strobe_o),
    .printer_byte_o       (printer_byte_o),
    .partner_read_byte_o  (partner_read_byte_o),
    .partner_read_valid_o (partner_read_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Opening accesses: reset values, byte extremes, both handshake strobes,
  // printer path, fetch with and without read-ready, port C high half
  // rebuilt from the flags, and port C writes ignored once both halves are input.
  access_row_t opening_accesses [24] = '{
    '{CMD_HOST_READ,     PORT_A,    8'h00, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_B,    8'hFF, 8'hFF, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_C,    8'h00, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_CTRL, 8'h00, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_PARTNER_FETCH, PORT_A,    8'h00, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_A,    8'hFF, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_C,    8'h01, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_A,    8'hA5, 8'h00, 1'b1, '{8'h00, 1'b1, 8'hA5, 8'h00, 1'b0}},
    '{CMD_PARTNER_FETCH, PORT_B,    8'h00, 8'h00, 1'b0, ALL_ZERO},
    '{CMD_PARTNER_FETCH, PORT_C,    8'h00, 8'h00, 1'b0, ALL_ZERO},
    '{CMD_PARTNER_PUT,   PORT_CTRL, 8'hFF, 8'h5A, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_C,    8'h0D, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_B,    8'h00, 8'h00, 1'b0, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_C,    8'h00, 8'h00, 1'b0, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_CTRL, 8'h08, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_PARTNER_PUT,   PORT_A,    8'h00, 8'hFF, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_C,    8'hF7, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_C,    8'h00, 8'h00, 1'b0, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_CTRL, 8'h89, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_C,    8'h00, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_C,    8'h00, 8'h00, 1'b0, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_CTRL, 8'hFF, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_WRITE,    PORT_CTRL, 8'h00, 8'h00, 1'b1, ALL_ZERO},
    '{CMD_HOST_READ,     PORT_A,    8'h00, 8'h00, 1'b0, ALL_ZERO}
  };

  // Predictor copy of the block state.
  logic [7:0] lat_a, lat_b, lat_c_hi, mode_reg, disk_in_byte, disk_out_byte;
  logic [3:0] lat_c_lo;
  logic       disk_wr_rdy, disk_rd_rdy;

  res_t       pending_results [$];
  bit         failed        = 1'b0;
  bit         quiet_phase   = 1'b0;
  int unsigned idle_cycles  = 0;

  // Row info travels with the input transaction so the monitor can pick it up.
  bit         row_typed_q   = 1'b0;
  res_t       row_want_q    = '0;

  function automatic res_t pio_access(command_e cmd, port_e port,
                                      logic [7:0] hb, logic [7:0] db);
    res_t r;
    r = '0;
    case (cmd)
      CMD_HOST_READ: begin
        case (port)
          PORT_A: r.read_byte = lat_a;
          PORT_B: r.read_byte = lat_b;
          PORT_C: begin
            // High half as input: rebuilt from the flags, bit 6 kept, bit 7 cleared.
            if (mode_reg[MODE_C_HIGH_IN])
              lat_c_hi = {1'b0, lat_c_hi[6], disk_rd_rdy, disk_wr_rdy, 4'h0};
            r.read_byte = {lat_c_hi[7:4], lat_c_lo};
          end
          default: r.read_byte = '0;
        endcase
      end
      CMD_HOST_WRITE: begin
        case (port)
          PORT_A: begin
            lat_a = hb;
            if (lat_c_lo[PC_PRINTER]) begin
              r.printer_strobe = 1'b1;
              r.printer_byte   = hb;
            end
          end
          PORT_B: lat_b = hb;
          PORT_C: begin
            if (!mode_reg[MODE_C_LOW_IN]) begin
              lat_c_lo = hb[3:0];
              if (!lat_c_lo[PC_TAKE_B]) begin
                lat_b       = disk_in_byte;
                disk_wr_rdy = 1'b0;
              end
              if (!lat_c_lo[PC_GIVE_A]) begin
                disk_out_byte = lat_a;
                disk_rd_rdy   = 1'b1;
              end
            end
            if (!mode_reg[MODE_C_HIGH_IN])
              lat_c_hi = {hb[7:4], 4'h0};
          end
          default: mode_reg = hb;  // bit 7 is not a bit set/reset command
        endcase
      end
      CMD_PARTNER_PUT: begin
        disk_in_byte = db;
        disk_wr_rdy  = 1'b1;
      end
      default: begin
        r.partner_read_byte  = disk_out_byte;
        r.partner_read_valid = disk_rd_rdy;
        disk_rd_rdy          = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Half with no gap, most others short, a few long ones; none at all in a quiet phase.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_access(command_e cmd, port_e port, logic [7:0] hb,
                             logic [7:0] db, bit typed, res_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    port_select_i  <= port;
    host_byte_i    <= hb;
    partner_byte_i <= db;
    row_typed_q    <= typed;
    row_want_q     <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Result stalls: random bursts, with free stretches in between.
  initial begin
    int unsigned stall_len;
    wait (rst_ni);
    forever begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Monitor: result check first, then the prediction for a newly accepted transaction.
  res_t want_res, got_res, model_res;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;

      if (out_valid_o && !out_stall_i) begin
        got_res = '{read_byte_o, printer_strobe_o, printer_byte_o,
                    partner_read_byte_o, partner_read_valid_o};
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          failed = 1'b1;
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.read_byte !== want_res.read_byte) begin
            $error("read_byte: expected %02h, got %02h", want_res.read_byte, got_res.read_byte);
            failed = 1'b1;
          end
          if (got_res.printer_strobe !== want_res.printer_strobe) begin
            $error("printer_strobe: expected %0b, got %0b",
                   want_res.printer_strobe, got_res.printer_strobe);
            failed = 1'b1;
          end
          if (got_res.printer_byte !== want_res.printer_byte) begin
            $error("printer_byte: expected %02h, got %02h",
                   want_res.printer_byte, got_res.printer_byte);
            failed = 1'b1;
          end
          if (got_res.partner_read_byte !== want_res.partner_read_byte) begin
            $error("partner_read_byte: expected %02h, got %02h",
                   want_res.partner_read_byte, got_res.partner_read_byte);
            failed = 1'b1;
          end
          if (got_res.partner_read_valid !== want_res.partner_read_valid) begin
            $error("partner_read_valid: expected %0b, got %0b",
                   want_res.partner_read_valid, got_res.partner_read_valid);
            failed = 1'b1;
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        // Predictor state advances on every row, typed or not.
        model_res = pio_access(command_e'(command_i), port_e'(port_select_i),
                               host_byte_i, partner_byte_i);
        pending_results.push_back(row_typed_q ? row_want_q : model_res);
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("pio_mode0_with_disk_handshake_top regression: fail");
    $finish;
  end

  initial begin
    lat_a = '0; lat_b = '0; lat_c_lo = '0; lat_c_hi = '0; mode_reg = '0;
    disk_in_byte = '0; disk_out_byte = '0; disk_wr_rdy = 1'b0; disk_rd_rdy = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (opening_accesses[i])
      send_access(opening_accesses[i].cmd, opening_accesses[i].port,
                  opening_accesses[i].host_byte, opening_accesses[i].disk_byte,
                  opening_accesses[i].typed, opening_accesses[i].want);

    for (int unsigned n = 0; n < RANDOM_ACCESSES; n++) begin
      // One stretch of back-to-back traffic with no stalls.
      quiet_phase = (n >= 400 && n < 500);
      send_access(command_e'($urandom_range(0, 3)), port_e'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, ALL_ZERO);
    end
    quiet_phase = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed && pending_results.size() == 0)
      $display("pio_mode0_with_disk_handshake_top regression: pass");
    else
      $display("pio_mode0_with_disk_handshake_top regression: fail");
    $finish;
  end

endmodule

// ----- pio_mode0_with_disk_handshake_top.f -----
sv/piodh_pkg.sv
sv/piodh_core.sv
sv/pio_mode0_with_disk_handshake_top.sv
verif/tb_top.sv
